// File: rtl/rtspd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rtspd_pkg;

  localparam int LEN_W = 16;

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_CHAN,
    PH_LEN_HI,
    PH_LEN_LO,
    PH_PAYLOAD,
    PH_HEADERS,
    PH_BODY
  } phase_t;

  localparam logic [2:0] KIND_RTP      = 3'd0;
  localparam logic [2:0] KIND_RTSP     = 3'd1;
  localparam logic [2:0] KIND_ANNOUNCE = 3'd2;
  localparam logic [2:0] KIND_REDIRECT = 3'd3;
  localparam logic [2:0] KIND_ERROR    = 3'd4;

  localparam logic [63:0] LEAD_RTSP     = 64'h525453502F312E30;
  localparam logic [63:0] LEAD_ANNOUNCE = 64'h414E4E4F554E4345;
  localparam logic [63:0] LEAD_REDIRECT = 64'h5245444952454354;

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;

  localparam logic [3:0] FNM_VALUE = 4'd15;

  typedef struct packed {
    logic       emit;
    logic       burst;
    logic [7:0] data;
    logic [2:0] kind;
    logic       has_byte;
    logic       last;
  } res_t;

  function automatic logic [7:0] lead_byte(input logic [2:0] pos);
    logic [5:0] sh;
    sh = {3'd7 - pos, 3'b000};
    return LEAD_RTSP[sh +: 8];
  endfunction

  function automatic logic [7:0] field_char(input logic [3:0] k);
    logic [7:0] c;
    case (k)
      4'd0:    c = "C";
      4'd1:    c = "o";
      4'd2:    c = "n";
      4'd3:    c = "t";
      4'd4:    c = "e";
      4'd5:    c = "n";
      4'd6:    c = "t";
      4'd7:    c = "-";
      4'd8:    c = "L";
      4'd9:    c = "e";
      4'd10:   c = "n";
      4'd11:   c = "g";
      4'd12:   c = "t";
      4'd13:   c = "h";
      4'd14:   c = ":";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// File: rtl/rtspd_parser.sv
`timescale 1ns / 1ps
`default_nettype none

module rtspd_parser (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [7:0]          in_data_byte,
  input  wire logic                cfg_wr_en,
  input  wire logic [7:0]          cfg_rtp_channel,
  input  wire logic                load_ok,
  output logic                     push,
  output rtspd_pkg::res_t          res
);

  logic                          in_valid_r;
  logic [7:0]                    in_byte_r;
  logic [7:0]                    rtp_channel_r;
  rtspd_pkg::phase_t             phase_r, phase_nxt;
  logic [63:0]                   window_r, window_nxt;
  logic [2:0]                    lcount_r, lcount_nxt;
  logic                          match_r, match_nxt;
  logic [rtspd_pkg::LEN_W-1:0]   rem_r, rem_nxt;
  logic [1:0]                    blm_r, blm_nxt;
  logic [3:0]                    fnm_r, fnm_nxt;
  logic [rtspd_pkg::LEN_W-1:0]   clen_r, clen_nxt;
  logic                          supp_r, supp_nxt;
  logic                          adv;
  logic [7:0]                    b;
  logic [rtspd_pkg::LEN_W-1:0]   rem_dec;
  logic [rtspd_pkg::LEN_W+3:0]   cl_mul;
  logic [63:0]                   shifted;
  logic                          done;

  assign b        = in_byte_r;
  assign adv      = in_valid_r && (!res.emit || load_ok);
  assign push     = adv && res.emit;
  assign in_ready = !in_valid_r || adv;
  assign rem_dec  = (rem_r == '0) ? '0 : rem_r - 1'b1;
  assign shifted  = {window_r[55:0], b};
  assign cl_mul   = ({4'b0000, clen_r} << 3) + ({4'b0000, clen_r} << 1)
                  + {{rtspd_pkg::LEN_W{1'b0}}, b[3:0]};

  always_comb begin
    phase_nxt  = phase_r;
    window_nxt = window_r;
    lcount_nxt = lcount_r;
    match_nxt  = match_r;
    rem_nxt    = rem_r;
    blm_nxt    = blm_r;
    fnm_nxt    = fnm_r;
    clen_nxt   = clen_r;
    supp_nxt   = supp_r;
    done       = 1'b0;
    res        = '0;
    case (phase_r)
      rtspd_pkg::PH_IDLE: begin
        if (lcount_r == 3'd0 && b == rtspd_pkg::CH_DOLLAR) begin
          phase_nxt = rtspd_pkg::PH_CHAN;
        end else if (lcount_r != 3'd7) begin
          window_nxt = shifted;
          lcount_nxt = lcount_r + 3'd1;
        end else begin
          lcount_nxt   = 3'd0;
          window_nxt   = '0;
          res.emit     = 1'b1;
          res.last     = 1'b1;
          res.kind     = rtspd_pkg::KIND_ERROR;
          if (shifted == rtspd_pkg::LEAD_RTSP || shifted == rtspd_pkg::LEAD_ANNOUNCE ||
              shifted == rtspd_pkg::LEAD_REDIRECT) begin
            phase_nxt = rtspd_pkg::PH_HEADERS;
            supp_nxt  = 1'b1;
            blm_nxt   = 2'd0;
            fnm_nxt   = 4'd0;
            clen_nxt  = '0;
            rem_nxt   = '0;
          end
          if (shifted == rtspd_pkg::LEAD_RTSP) begin
            supp_nxt     = 1'b0;
            res.burst    = 1'b1;
            res.data     = rtspd_pkg::lead_byte(3'd0);
            res.kind     = rtspd_pkg::KIND_RTSP;
            res.has_byte = 1'b1;
            res.last     = 1'b0;
          end else if (shifted == rtspd_pkg::LEAD_ANNOUNCE) begin
            res.kind = rtspd_pkg::KIND_ANNOUNCE;
          end else if (shifted == rtspd_pkg::LEAD_REDIRECT) begin
            res.kind = rtspd_pkg::KIND_REDIRECT;
          end
        end
      end
      rtspd_pkg::PH_CHAN: begin
        match_nxt = (b == rtp_channel_r);
        phase_nxt = rtspd_pkg::PH_LEN_HI;
      end
      rtspd_pkg::PH_LEN_HI: begin
        rem_nxt   = {{(rtspd_pkg::LEN_W-8){1'b0}}, b};
        phase_nxt = rtspd_pkg::PH_LEN_LO;
      end
      rtspd_pkg::PH_LEN_LO: begin
        rem_nxt = {rem_r[7:0], b};
        if (rem_r[7:0] == 8'd0 && b == 8'd0) begin
          res.emit  = match_r;
          res.kind  = rtspd_pkg::KIND_RTP;
          res.last  = 1'b1;
          phase_nxt = rtspd_pkg::PH_IDLE;
        end else begin
          phase_nxt = rtspd_pkg::PH_PAYLOAD;
        end
      end
      rtspd_pkg::PH_PAYLOAD, rtspd_pkg::PH_BODY: begin
        res.emit     = (phase_r == rtspd_pkg::PH_PAYLOAD) ? match_r : !supp_r;
        res.kind     = (phase_r == rtspd_pkg::PH_PAYLOAD) ? rtspd_pkg::KIND_RTP
                                                           : rtspd_pkg::KIND_RTSP;
        res.data     = b;
        res.has_byte = 1'b1;
        res.last     = (rem_r == {{(rtspd_pkg::LEN_W-1){1'b0}}, 1'b1});
        rem_nxt      = rem_dec;
        if (rem_dec == '0) begin
          phase_nxt = rtspd_pkg::PH_IDLE;
        end
      end
      rtspd_pkg::PH_HEADERS: begin
        if (fnm_r == rtspd_pkg::FNM_VALUE) begin
          if (b >= "0" && b <= "9") begin
            clen_nxt = (cl_mul[rtspd_pkg::LEN_W+3:rtspd_pkg::LEN_W] != 4'd0) ? '1
                     : cl_mul[rtspd_pkg::LEN_W-1:0];
          end else if (b != rtspd_pkg::CH_SPACE && b != rtspd_pkg::CH_TAB) begin
            fnm_nxt = 4'd0;
          end
        end else if (fnm_r == 4'd0) begin
          if (blm_r == 2'd2 && b == rtspd_pkg::field_char(4'd0)) begin
            fnm_nxt = 4'd1;
          end
        end else if (b == rtspd_pkg::field_char(fnm_r)) begin
          fnm_nxt = fnm_r + 4'd1;
          if (fnm_r == 4'd14) begin
            clen_nxt = '0;
          end
        end else begin
          fnm_nxt = 4'd0;
        end
        if (b == rtspd_pkg::CH_CR) begin
          blm_nxt = (blm_r == 2'd2) ? 2'd3 : 2'd1;
        end else if (b == rtspd_pkg::CH_LF) begin
          done    = (blm_r == 2'd3);
          blm_nxt = (blm_r == 2'd1) ? 2'd2 : 2'd0;
        end else begin
          blm_nxt = 2'd0;
        end
        res.emit     = !supp_r;
        res.kind     = rtspd_pkg::KIND_RTSP;
        res.data     = b;
        res.has_byte = 1'b1;
        if (done) begin
          blm_nxt   = 2'd0;
          fnm_nxt   = 4'd0;
          rem_nxt   = clen_nxt;
          res.last  = (clen_nxt == '0);
          phase_nxt = (clen_nxt == '0) ? rtspd_pkg::PH_IDLE : rtspd_pkg::PH_BODY;
        end
      end
      default: begin
        phase_nxt = rtspd_pkg::PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r    <= 1'b0;
      rtp_channel_r <= 8'd0;
      phase_r       <= rtspd_pkg::PH_IDLE;
      window_r      <= '0;
      lcount_r      <= 3'd0;
      match_r       <= 1'b0;
      rem_r         <= '0;
      blm_r         <= 2'd0;
      fnm_r         <= 4'd0;
      clen_r        <= '0;
      supp_r        <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        rtp_channel_r <= cfg_rtp_channel;
      end
      if (in_ready) begin
        in_valid_r <= in_valid;
      end
      if (adv) begin
        phase_r  <= phase_nxt;
        window_r <= window_nxt;
        lcount_r <= lcount_nxt;
        match_r  <= match_nxt;
        rem_r    <= rem_nxt;
        blm_r    <= blm_nxt;
        fnm_r    <= fnm_nxt;
        clen_r   <= clen_nxt;
        supp_r   <= supp_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_byte_r <= in_data_byte;
    end
  end

endmodule

`default_nettype wire

// File: rtl/rtspd_out.sv
`timescale 1ns / 1ps
`default_nettype none

module rtspd_out (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire rtspd_pkg::res_t  res,
  output logic                  load_ok,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [7:0]            out_byte,
  output logic [2:0]            out_kind,
  output logic                  out_has_byte,
  output logic                  out_last
);

  logic       valid_r;
  logic       burst_r;
  logic [2:0] pos_r;
  logic [7:0] byte_r;
  logic [2:0] kind_r;
  logic       has_r;
  logic       last_r;
  logic       taken;

  assign taken   = valid_r && out_ready;
  assign load_ok = !valid_r || (out_ready && !burst_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      burst_r <= 1'b0;
      pos_r   <= 3'd0;
    end else if (push) begin
      valid_r <= 1'b1;
      burst_r <= res.burst;
      pos_r   <= 3'd0;
    end else if (taken && burst_r) begin
      pos_r   <= pos_r + 3'd1;
      burst_r <= (pos_r != 3'd6);
    end else if (taken) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      byte_r <= res.data;
      kind_r <= res.kind;
      has_r  <= res.has_byte;
      last_r <= res.last;
    end else if (taken && burst_r) begin
      byte_r <= rtspd_pkg::lead_byte(pos_r + 3'd1);
    end
  end

  assign out_valid    = valid_r;
  assign out_byte     = byte_r;
  assign out_kind     = kind_r;
  assign out_has_byte = has_r;
  assign out_last     = last_r;

endmodule

`default_nettype wire

// File: rtl/rtsp_interleaved_demux.sv
`timescale 1ns / 1ps
`default_nettype none

// Splitter for a TCP byte stream that mixes RTSP messages with interleaved
// RTP frames. Bytes enter on the in_ channel and result requests leave on
// the out_ channel, both with valid and ready.
// An RTP payload byte of the selected channel, or a byte of an RTSP
// response, comes out as one request; it passes through the input
// register and then the result register.
// One byte is accepted per cycle unless in_ready is low. The RTSP/1.0
// lead gives eight requests from one byte, and while the result register
// serves them at most one further byte waits in the input register.
// Announce, redirect and bad leads give one event request with last set.
// cfg_wr_en writes cfg_rtp_channel at once; write it only while idle.
// Reset clears the parser state, the channel register and both valid
// flags. When the receiver stalls, the result register holds its request,
// the input register fills and then in_ready drops until out_ready rises.

module rtsp_interleaved_demux (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_data_byte,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_byte,
  output logic [2:0]      out_kind,
  output logic            out_has_byte,
  output logic            out_last,
  input  wire logic       cfg_wr_en,
  input  wire logic [7:0] cfg_rtp_channel
);

  rtspd_pkg::res_t res;
  logic            push;
  logic            load_ok;

  rtspd_parser u_parser (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_data_byte    (in_data_byte),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_rtp_channel (cfg_rtp_channel),
    .load_ok         (load_ok),
    .push            (push),
    .res             (res)
  );

  rtspd_out u_out (
    .clk          (clk),
    .rst_n        (rst_n),
    .push         (push),
    .res          (res),
    .load_ok      (load_ok),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_byte     (out_byte),
    .out_kind     (out_kind),
    .out_has_byte (out_has_byte),
    .out_last     (out_last)
  );

endmodule

`default_nettype wire

// File: rtl/rtspd_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module rtspd_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] out_byte,
  input wire logic [2:0] out_kind,
  input wire logic       out_has_byte,
  input wire logic       out_last
);

  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("Result request present right after reset.");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(out_kind)
      && $stable(out_has_byte) && $stable(out_last))
    else $error("Stalled result request changed.");

  a_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_kind == rtspd_pkg::KIND_RTP || out_kind == rtspd_pkg::KIND_RTSP
      || out_kind == rtspd_pkg::KIND_ANNOUNCE || out_kind == rtspd_pkg::KIND_REDIRECT
      || out_kind == rtspd_pkg::KIND_ERROR)
    else $error("Result request with an undefined kind.");

  a_event: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == rtspd_pkg::KIND_ANNOUNCE
      || out_kind == rtspd_pkg::KIND_REDIRECT || out_kind == rtspd_pkg::KIND_ERROR)
    |-> out_last && !out_has_byte && out_byte == 8'd0)
    else $error("Event request carries data or lacks last.");

  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_has_byte |-> out_last && out_byte == 8'd0)
    else $error("Empty request is not final.");

endmodule

bind rtsp_interleaved_demux rtspd_checker u_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .out_byte     (out_byte),
  .out_kind     (out_kind),
  .out_has_byte (out_has_byte),
  .out_last     (out_last)
);

`default_nettype wire

// File: sim/rtsp_interleaved_demux_test.sv
`timescale 1ns / 1ps

module rtsp_interleaved_demux_test;

  localparam int CYCLE_LIMIT = 500000;
  localparam int SETTLE_CYCLES = 16;
  localparam int HOLD_CYCLES = 400;
  localparam int PHASE_BYTES = 8;

  typedef struct packed {
    logic [7:0] data;
    logic [2:0] kind;
    logic       has_byte;
    logic       last;
  } demux_item_t;

  class demux_scoreboard;
    localparam logic [rtspd_pkg::LEN_W-1:0] LEN_MAX = '1;
    localparam logic [7:0] DIGIT_0 = 8'h30;
    localparam logic [7:0] DIGIT_9 = 8'h39;

    string                       length_field = "Content-Length:";
    logic [7:0]                  channel;
    rtspd_pkg::phase_t           phase;
    logic [63:0]                 lead_window;
    logic [2:0]                  lead_count;
    bit                          channel_match;
    logic [rtspd_pkg::LEN_W-1:0] remaining;
    logic [1:0]                  blank_seen;
    logic [3:0]                  name_pos;
    logic [rtspd_pkg::LEN_W-1:0] body_len;
    bit                          muted;
    int                          produced;
    int                          errors;
    demux_item_t                 outputs_due[$];

    function new();
      channel = '0;
      phase = rtspd_pkg::PH_IDLE;
      lead_window = '0;
      lead_count = '0;
      channel_match = 1'b0;
      remaining = '0;
      blank_seen = '0;
      name_pos = '0;
      body_len = '0;
      muted = 1'b0;
      produced = 0;
      errors = 0;
    endfunction

    function void add_due(logic [7:0] data, logic [2:0] kind, logic has_byte, logic last);
      demux_item_t item;
      item.data = data;
      item.kind = kind;
      item.has_byte = has_byte;
      item.last = last;
      outputs_due.push_back(item);
      produced++;
    endfunction

    function void open_message(bit skip);
      phase = rtspd_pkg::PH_HEADERS;
      muted = skip;
      blank_seen = '0;
      name_pos = '0;
      body_len = '0;
      remaining = '0;
    endfunction

    function void track_length(logic [7:0] b, bit line_start);
      longint value;
      if (name_pos == rtspd_pkg::FNM_VALUE) begin
        if (b >= DIGIT_0 && b <= DIGIT_9) begin
          value = longint'(body_len) * 10 + longint'(b - DIGIT_0);
          body_len = (value > LEN_MAX) ? LEN_MAX : value[rtspd_pkg::LEN_W-1:0];
        end else if (b != rtspd_pkg::CH_SPACE && b != rtspd_pkg::CH_TAB) begin
          name_pos = '0;
        end
      end else if (name_pos == 0) begin
        if (line_start && b == length_field[0]) name_pos = 4'd1;
      end else if (b == length_field[name_pos]) begin
        name_pos++;
        if (name_pos == rtspd_pkg::FNM_VALUE) body_len = '0;
      end else begin
        name_pos = '0;
      end
    endfunction

    // Returns the number of results that the accepted request gives.
    function int note_request(logic [7:0] b);
      bit          line_start;
      bit          done;
      logic [31:0] frame_len;
      produced = 0;
      case (phase)
        rtspd_pkg::PH_IDLE: begin
          if (lead_count == 0 && b == rtspd_pkg::CH_DOLLAR) begin
            phase = rtspd_pkg::PH_CHAN;
          end else begin
            lead_window = {lead_window[55:0], b};
            if (lead_count < 3'd7) begin
              lead_count++;
            end else begin
              lead_count = '0;
              if (lead_window == rtspd_pkg::LEAD_RTSP) begin
                for (int i = 0; i < 8; i++)
                  add_due(lead_window[8 * (7 - i) +: 8], rtspd_pkg::KIND_RTSP, 1'b1, 1'b0);
                open_message(1'b0);
              end else if (lead_window == rtspd_pkg::LEAD_ANNOUNCE) begin
                add_due(8'h00, rtspd_pkg::KIND_ANNOUNCE, 1'b0, 1'b1);
                open_message(1'b1);
              end else if (lead_window == rtspd_pkg::LEAD_REDIRECT) begin
                add_due(8'h00, rtspd_pkg::KIND_REDIRECT, 1'b0, 1'b1);
                open_message(1'b1);
              end else begin
                add_due(8'h00, rtspd_pkg::KIND_ERROR, 1'b0, 1'b1);
              end
              lead_window = '0;
            end
          end
        end
        rtspd_pkg::PH_CHAN: begin
          channel_match = (b == channel);
          phase = rtspd_pkg::PH_LEN_HI;
        end
        rtspd_pkg::PH_LEN_HI: begin
          remaining = rtspd_pkg::LEN_W'(b);
          phase = rtspd_pkg::PH_LEN_LO;
        end
        rtspd_pkg::PH_LEN_LO: begin
          frame_len = {16'h0000, remaining[7:0], b};
          remaining = (frame_len > LEN_MAX) ? LEN_MAX : frame_len[rtspd_pkg::LEN_W-1:0];
          if (remaining == 0) begin
            if (channel_match) add_due(8'h00, rtspd_pkg::KIND_RTP, 1'b0, 1'b1);
            phase = rtspd_pkg::PH_IDLE;
          end else begin
            phase = rtspd_pkg::PH_PAYLOAD;
          end
        end
        rtspd_pkg::PH_PAYLOAD: begin
          if (channel_match) add_due(b, rtspd_pkg::KIND_RTP, 1'b1, remaining == 1);
          if (remaining > 0) remaining--;
          if (remaining == 0) phase = rtspd_pkg::PH_IDLE;
        end
        rtspd_pkg::PH_HEADERS: begin
          line_start = (blank_seen == 2'd2);
          done = 1'b0;
          track_length(b, line_start);
          if (b == rtspd_pkg::CH_CR) begin
            blank_seen = (blank_seen == 2'd2) ? 2'd3 : 2'd1;
          end else if (b == rtspd_pkg::CH_LF) begin
            if (blank_seen == 2'd3) done = 1'b1;
            blank_seen = (blank_seen == 2'd1) ? 2'd2 : 2'd0;
          end else begin
            blank_seen = 2'd0;
          end
          if (done) begin
            blank_seen = '0;
            name_pos = '0;
            remaining = body_len;
          end
          if (!muted) add_due(b, rtspd_pkg::KIND_RTSP, 1'b1, done && remaining == 0);
          if (done) phase = (remaining == 0) ? rtspd_pkg::PH_IDLE : rtspd_pkg::PH_BODY;
        end
        rtspd_pkg::PH_BODY: begin
          if (!muted) add_due(b, rtspd_pkg::KIND_RTSP, 1'b1, remaining == 1);
          if (remaining > 0) remaining--;
          if (remaining == 0) phase = rtspd_pkg::PH_IDLE;
        end
        default: begin
          phase = rtspd_pkg::PH_IDLE;
        end
      endcase
      return produced;
    endfunction

    function void check_result(logic [7:0] data, logic [2:0] kind, logic has_byte,
                               logic last);
      demux_item_t want;
      if (outputs_due.size() == 0) begin
        $display("%0t: unexpected result byte %h kind %0d has_byte %b last %b",
                 $time, data, kind, has_byte, last);
        errors++;
      end else begin
        want = outputs_due.pop_front();
        if (data !== want.data || kind !== want.kind || has_byte !== want.has_byte ||
            last !== want.last) begin
          $display("%0t: expected %h/%0d/%b/%b, got %h/%0d/%b/%b",
                   $time, want.data, want.kind, want.has_byte, want.last,
                   data, kind, has_byte, last);
          errors++;
        end
      end
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_data_byte = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_byte;
  logic [2:0] out_kind;
  logic       out_has_byte;
  logic       out_last;
  logic       cfg_wr_en = 1'b0;
  logic [7:0] cfg_rtp_channel = 8'h00;

  demux_scoreboard board = new();
  logic [7:0]      tx_bytes[$];
  int              idle_pct = 0;
  int              stall_pct = 0;
  int              sent_bytes = 0;
  int              cycle_count = 0;
  bit              long_hold = 1'b0;

  rtsp_interleaved_demux i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_data_byte    (in_data_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_byte        (out_byte),
    .out_kind        (out_kind),
    .out_has_byte    (out_has_byte),
    .out_last        (out_last),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_rtp_channel (cfg_rtp_channel)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      board.check_result(out_byte, out_kind, out_has_byte, out_last);
  end

  initial begin
    forever begin
      @(negedge clk);
      if (long_hold) begin
        long_hold = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  function automatic int idle_gap(input int pct);
    int gap;
    gap = 0;
    while ($urandom_range(0, 99) < pct) gap++;
    return gap;
  endfunction

  function automatic void add_byte(input logic [7:0] b);
    tx_bytes.push_back(b);
  endfunction

  function automatic void add_text(input string s);
    foreach (s[i]) tx_bytes.push_back(s[i]);
  endfunction

  function automatic void add_crlf();
    add_byte(rtspd_pkg::CH_CR);
    add_byte(rtspd_pkg::CH_LF);
  endfunction

  function automatic void add_line(input string s);
    add_text(s);
    add_crlf();
  endfunction

  function automatic void add_lead(input logic [63:0] lead);
    for (int i = 7; i >= 0; i--) add_byte(lead[8 * i +: 8]);
  endfunction

  function automatic void add_rtp_header(input logic [7:0] ch, input logic [15:0] len);
    add_byte(rtspd_pkg::CH_DOLLAR);
    add_byte(ch);
    add_byte(len[15:8]);
    add_byte(len[7:0]);
  endfunction

  // A header line never holds a line feed, so it cannot end the headers early.
  function automatic void add_random_line();
    logic [7:0] b;
    repeat ($urandom_range(1, 6)) begin
      b = $urandom_range(0, 255);
      add_byte((b == rtspd_pkg::CH_LF) ? rtspd_pkg::CH_SPACE : b);
    end
    add_crlf();
  endfunction

  function automatic void add_random_message(input logic [63:0] lead);
    int    len;
    int    form;
    string digits;
    len = $urandom_range(0, 4);
    form = $urandom_range(0, 9);
    digits = $sformatf("%0d", len);
    if ($urandom_range(0, 3) == 0) digits = {"0", digits};
    add_lead(lead);
    if ($urandom_range(0, 1) != 0) add_random_line();
    else add_crlf();
    if (form <= 2) begin
      add_text("Content-Length:");
      repeat ($urandom_range(0, 2))
        add_byte(($urandom_range(0, 1) != 0) ? rtspd_pkg::CH_SPACE : rtspd_pkg::CH_TAB);
      add_line(digits);
    end else if (form == 3) begin
      add_line({"Content-Length: ", digits, "z9"});
    end else if (form == 4) begin
      add_line({"Content-Lenght: ", digits});
      len = 0;
    end else begin
      len = 0;
    end
    add_crlf();
    repeat (len) add_byte($urandom_range(0, 255));
  endfunction

  function automatic void add_bad_lead();
    logic [7:0] first;
    do begin
      first = $urandom_range(0, 255);
    end while (first == rtspd_pkg::CH_DOLLAR);
    add_byte(first);
    repeat (7) add_byte($urandom_range(0, 255));
  endfunction

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = idle_gap(idle_pct);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data_byte <= b;
    do begin
      @(posedge clk);
    end while (!in_ready);
    void'(board.note_request(b));
    sent_bytes++;
  endtask

  task automatic send_queued();
    while (tx_bytes.size() > 0) send_byte(tx_bytes.pop_front());
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (board.outputs_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_channel(input logic [7:0] ch);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_rtp_channel <= ch;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    board.channel = ch;
  endtask

  task automatic send_random_unit();
    int         pick;
    logic [7:0] ch;
    pick = $urandom_range(0, 99);
    if (pick < 35) begin
      ch = ($urandom_range(0, 2) != 0) ? board.channel : 8'($urandom_range(0, 255));
      add_rtp_header(ch, 16'($urandom_range(0, 6)));
      repeat ({tx_bytes[tx_bytes.size() - 2], tx_bytes[tx_bytes.size() - 1]})
        add_byte($urandom_range(0, 255));
    end else if (pick < 65) begin
      add_random_message(rtspd_pkg::LEAD_RTSP);
    end else if (pick < 75) begin
      add_random_message(rtspd_pkg::LEAD_ANNOUNCE);
    end else if (pick < 85) begin
      add_random_message(rtspd_pkg::LEAD_REDIRECT);
    end else begin
      add_bad_lead();
    end
    send_queued();
  endtask

  task automatic run_random_phase(input int idle, input int stall, input logic [7:0] ch);
    write_channel(ch);
    idle_pct = idle;
    stall_pct = stall;
    sent_bytes = 0;
    while (sent_bytes < PHASE_BYTES) send_random_unit();
    drain();
  endtask

  initial begin
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    write_channel(8'h00);

    add_rtp_header(8'h00, 16'd2);
    add_byte(8'h00);
    add_byte(8'hFF);
    add_rtp_header(8'h00, 16'd0);
    add_lead(rtspd_pkg::LEAD_RTSP);
    add_crlf();
    add_text("Content-Length:");
    add_byte(rtspd_pkg::CH_TAB);
    add_line(" 02x");
    add_crlf();
    add_text("ok");
    add_lead(rtspd_pkg::LEAD_ANNOUNCE);
    add_crlf();
    add_crlf();
    add_text("A$BCDEFG");
    send_queued();

    // The receiver stops for a long time while this response streams in.
    long_hold = 1'b1;
    add_lead(rtspd_pkg::LEAD_RTSP);
    add_crlf();
    add_crlf();
    send_queued();
    drain();

    run_random_phase(86, 0, 8'($urandom_range(0, 255)));
    run_random_phase(0, 86, rtspd_pkg::CH_DOLLAR);
    run_random_phase(23, 23, 8'hFF);

    if (board.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
